// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker of this block.
// Each macro samples on clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/ita_pkg.sv =====
// Package for the integer to ASCII formatter: modes, controller states, cell controls
// and the character tables. Used by the formatter, chain and cell RTL files.
`timescale 1ns / 1ps

package ita_pkg;

	localparam int VALUE_W   = 64;
	localparam int NUM_CELLS = 20;   // enough decimal digits for any 64-bit magnitude
	localparam int CONV_STEPS = VALUE_W;

	localparam logic [1:0] MODE_DEC    = 2'd0;
	localparam logic [1:0] MODE_HEX_LO = 2'd1;
	localparam logic [1:0] MODE_HEX_UP = 2'd2;
	localparam logic [1:0] MODE_PTR    = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_PREFIX,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_BIT,
		CELL_DIGIT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     dec;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_MINUS,
		PFX_HEX,
		PFX_NIL
	} prefix_t;

	function automatic logic [2:0] prefix_len(input prefix_t kind);
		logic [2:0] len;
		unique case (kind)
			PFX_NONE:  len = 3'd0;
			PFX_MINUS: len = 3'd1;
			PFX_HEX:   len = 3'd2;
			PFX_NIL:   len = 3'd5;
			default:   len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] prefix_char(input prefix_t kind, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h30;
		unique case (kind)
			PFX_MINUS: c = 8'h2d;                         // '-'
			PFX_HEX:   c = (idx == 3'd0) ? 8'h30 : 8'h78; // "0x"
			PFX_NIL: begin                                 // "(nil)"
				unique case (idx)
					3'd0:    c = 8'h28;
					3'd1:    c = 8'h6e;
					3'd2:    c = 8'h69;
					3'd3:    c = 8'h6c;
					3'd4:    c = 8'h29;
					default: c = 8'h29;
				endcase
			end
			PFX_NONE:  c = 8'h30;
			default:   c = 8'h30;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] letter;
		logic [7:0] c;
		letter = upper ? 8'h41 : 8'h61;
		if (d <= 4'd9) begin
			c = {4'd0, d} + 8'd48;
		end else begin
			c = letter + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/ita_cell.sv =====
// One digit cell of the conversion chain: a 4-bit digit with add-3 correction.
// Depends on ita_pkg.
`timescale 1ns / 1ps

module ita_cell (
	input  logic              clk,
	input  ita_pkg::cell_ctl_t ctl,
	input  logic              carry_in,
	input  logic [3:0]        digit_in,
	output logic              carry_out,
	output logic [3:0]        digit
);
	import ita_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] fixed;

	// in decimal, add 3 before the shift when the digit would pass 9 after doubling
	assign fixed     = (ctl.dec && digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry_out = fixed[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_CLEAR: digit_q <= 4'd0;
			CELL_BIT:   digit_q <= {fixed[2:0], carry_in};
			CELL_DIGIT: digit_q <= digit_in;
			CELL_HOLD:  digit_q <= digit_q;
			default:    digit_q <= digit_q;
		endcase
	end

endmodule

// ===== rtl/core/ita_chain.sv =====
// Row of digit cells, least significant digit in cell 0.
// Depends on ita_pkg and ita_cell.
`timescale 1ns / 1ps

module ita_chain (
	input  logic              clk,
	input  ita_pkg::cell_ctl_t ctl,
	input  logic              bit_in,
	output logic [3:0]        top_digit
);
	import ita_pkg::*;

	logic [NUM_CELLS:0] carry;
	logic [3:0]         digits [NUM_CELLS];
	logic [3:0]         digit_feed [NUM_CELLS];

	assign carry[0] = bit_in;

	// digit shifts move each digit one cell towards the top; zeros enter at cell 0
	assign digit_feed[0] = 4'd0;
	for (genvar i = 1; i < NUM_CELLS; i++) begin : g_feed
		assign digit_feed[i] = digits[i-1];
	end

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		ita_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.carry_in  (carry[i]),
			.digit_in  (digit_feed[i]),
			.carry_out (carry[i+1]),
			.digit     (digits[i])
		);
	end

	// carry out of the top cell is always zero for a 64-bit input
	assign top_digit = carry[NUM_CELLS] ? digits[NUM_CELLS-1] : digits[NUM_CELLS-1];

endmodule

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter. A request carries a 64-bit value and a mode: 0 signed
// decimal with a leading '-', 1 lowercase hex, 2 uppercase hex, 3 pointer ("(nil)" for
// zero, otherwise "0x" and lowercase hex). The block answers with one character per
// output request, most significant first, last high on the final one; every string
// has 1 to 20 characters. One value is worked on at a time: in_stall stays high from
// acceptance until the final character has been loaded into the output register.
// A value is accepted and then shifted, MSB first, through a row of 20 BCD/hex digit
// cells (one bit per cycle, add-3 correction in decimal); then the prefix characters
// are emitted, the leading zero cells are skipped (20 minus the digit count) and the
// digits are emitted, "(nil)" skipping the digit cells. Emission waits while the
// receiver stalls. Without back-pressure, most of the time per value goes into the
// 64-step shift through the cell row. The output register lets the last character
// of one value wait while the next value is taken.
// Depends on ita_pkg, ita_chain and ita_cell.
`timescale 1ns / 1ps

module integer_to_ascii_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  character,
	output logic        last
);
	import ita_pkg::*;

	localparam logic [5:0] CONV_LAST = 6'(CONV_STEPS - 1);
	localparam logic [4:0] CELLS_N   = 5'(NUM_CELLS);

	state_t state_q, state_nxt;

	logic [VALUE_W-1:0] value_q;    // magnitude, shifted out MSB first
	logic [5:0]         cnt_q;      // conversion steps left, minus one
	logic [4:0]         left_q;     // digit cells not yet emitted or skipped
	logic [2:0]         pfx_idx_q;
	prefix_t            kind_q;
	logic               dec_q;
	logic               upper_q;

	logic               out_valid_q;
	logic [7:0]         character_q;
	logic               last_q;

	cell_ctl_t          ctl;
	logic [3:0]         top_digit;
	logic               slot_free;
	logic               emit;
	logic [7:0]         emit_char;
	logic               emit_last;
	logic               lead_zero;
	logic [2:0]         pfx_len;

	logic [VALUE_W-1:0] mag_in;
	prefix_t            kind_in;

	ita_chain u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.bit_in    (value_q[VALUE_W-1]),
		.top_digit (top_digit)
	);

	// request decode: negative decimal values are converted as their magnitude;
	// the most negative value negates to itself, which is the right magnitude unsigned
	always_comb begin
		mag_in  = value;
		kind_in = PFX_NONE;
		unique case (mode)
			MODE_DEC: begin
				if (value[VALUE_W-1]) begin
					mag_in  = ~value + 64'd1;
					kind_in = PFX_MINUS;
				end
			end
			MODE_HEX_LO, MODE_HEX_UP: kind_in = PFX_NONE;
			MODE_PTR: kind_in = (value == 64'd0) ? PFX_NIL : PFX_HEX;
			default:  kind_in = PFX_NONE;
		endcase
	end

	assign slot_free = !out_valid_q || !out_stall;
	assign lead_zero = (top_digit == 4'd0) && (left_q > 5'd1);
	assign pfx_len   = prefix_len(kind_q);
	assign in_stall  = (state_q != ST_IDLE);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_CONV;
			end
			ST_CONV: begin
				if (cnt_q == 6'd0) state_nxt = (kind_q == PFX_NONE) ? ST_SKIP : ST_PREFIX;
			end
			ST_PREFIX: begin
				if (slot_free && pfx_idx_q == pfx_len - 3'd1)
					state_nxt = (kind_q == PFX_NIL) ? ST_IDLE : ST_SKIP;
			end
			ST_SKIP: begin
				if (!lead_zero) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free && left_q == 5'd1) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the controller: cell row control and character to load
	always_comb begin
		ctl.op    = CELL_HOLD;
		ctl.dec   = dec_q;
		emit      = 1'b0;
		emit_char = 8'h30;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) ctl.op = CELL_CLEAR;
			end
			ST_CONV: ctl.op = CELL_BIT;
			ST_PREFIX: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_char = prefix_char(kind_q, pfx_idx_q);
					emit_last = (kind_q == PFX_NIL) && (pfx_idx_q == pfx_len - 3'd1);
				end
			end
			ST_SKIP: begin
				if (lead_zero) ctl.op = CELL_DIGIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_char = digit_char(top_digit, upper_q);
					emit_last = (left_q == 5'd1);
					ctl.op    = CELL_DIGIT;
				end
			end
			default: ctl.op = CELL_HOLD;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= 6'd0;
			left_q      <= 5'd0;
			pfx_idx_q   <= 3'd0;
		end else begin
			state_q <= state_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE && in_valid) begin
				cnt_q     <= CONV_LAST;
				left_q    <= CELLS_N;
				pfx_idx_q <= 3'd0;
			end else begin
				if (state_q == ST_CONV) cnt_q <= cnt_q - 6'd1;
				if (state_q == ST_PREFIX && emit) pfx_idx_q <= pfx_idx_q + 3'd1;
				if (ctl.op == CELL_DIGIT) left_q <= left_q - 5'd1;
			end
		end
	end

	// request payload and output character register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			value_q <= mag_in;
			kind_q  <= kind_in;
			dec_q   <= (mode == MODE_DEC);
			upper_q <= (mode == MODE_HEX_UP);
		end else if (state_q == ST_CONV) begin
			value_q <= {value_q[VALUE_W-2:0], 1'b0};
		end
		if (emit) begin
			character_q <= emit_char;
			last_q      <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;

endmodule

// ===== rtl/core/ita_checker.sv =====
// Port-level checks for the integer to ASCII formatter, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ita_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] character,
	input logic       last
);

	// a waiting character holds until taken
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(character) && $stable(last))

	// a taken request makes the block busy
	`ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// a new request never overtakes an unfinished string
	`ASSERT_IMPL(a_accept_only_after_last, in_valid && !in_stall && out_valid, last)

	// mid-string characters leave the input side closed
	`ASSERT_IMPL(a_mid_string_busy, out_valid && !out_stall && !last, in_stall)

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (.*);

// ===== verif/testbench.sv =====
// Testbench for integer_to_ascii_formatter: directed and random requests in all four modes,
// with the expected text worked out here and checked character by character.
// Depends on ita_pkg (mode codes) and the formatter RTL.
`timescale 1ns / 1ps

module testbench;
	import ita_pkg::*;

	// A run with no request moving for this many cycles is taken as hung.
	localparam int HANG_LIMIT  = 3000;
	// Quiet cycles after the last character: longer than one full conversion.
	localparam int SETTLE_WAIT = 120;

	typedef struct {
		logic [7:0] ch;
		logic       lst;
	} text_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = MODE_DEC;
	logic [63:0] value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  character;
	logic        last;

	// Characters still owed by the block, oldest first.
	text_char_t  pending_text[$];
	int          error_count = 0;
	int          quiet_cycles = 0;
	// Percentages of cycles in which the sender idles / the receiver stalls.
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	integer_to_ascii_formatter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Text prediction: the string the block should produce for one request
	// ------------------------------------------------------------------

	// Append the digits of mag (base 10 or 16), most significant first.
	function automatic void append_digits(ref logic [7:0] text[$], input logic [63:0] mag,
			input int unsigned base, input logic upper_case);
		logic [7:0] rev[$];
		logic [7:0] letter_base;
		logic [63:0] d;
		letter_base = upper_case ? "A" : "a";
		// do/while: a zero magnitude still gives one '0'
		do begin
			d = mag % base;
			mag = mag / base;
			if (d <= 9)
				rev.push_back(8'd48 + d[7:0]);
			else
				rev.push_back(letter_base + d[7:0] - 8'd10);
		end while (mag != 0);
		while (rev.size() != 0)
			text.push_back(rev.pop_back());
	endfunction

	function automatic void predict_text(input logic [1:0] m, input logic [63:0] v);
		logic [7:0] text[$];
		text_char_t tc;
		case (m)
			MODE_DEC: begin
				// sign and magnitude; negating the most negative value wraps to
				// itself, which still reads correctly as unsigned
				if (v[63]) begin
					text.push_back("-");
					append_digits(text, -v, 10, 1'b0);
				end else begin
					append_digits(text, v, 10, 1'b0);
				end
			end
			MODE_HEX_LO: append_digits(text, v, 16, 1'b0);
			MODE_HEX_UP: append_digits(text, v, 16, 1'b1);
			default: begin
				// pointer: "(nil)" for zero, else "0x" and lowercase hex
				if (v == 0) begin
					text.push_back("(");
					text.push_back("n");
					text.push_back("i");
					text.push_back("l");
					text.push_back(")");
				end else begin
					text.push_back("0");
					text.push_back("x");
					append_digits(text, v, 16, 1'b0);
				end
			end
		endcase
		foreach (text[i]) begin
			tc.ch  = text[i];
			tc.lst = (i == text.size() - 1);
			pending_text.push_back(tc);
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus side
	// ------------------------------------------------------------------

	// Drive one request from a falling edge and hold it until taken. Valid is
	// left high on return; the next call (same falling edge) either replaces
	// the payload or drops valid, so nothing is taken twice.
	task automatic send_request(input logic [1:0] m, input logic [63:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		value    <= v;
		do
			@(posedge clk);
		while (in_stall);
		predict_text(m, v);
		@(negedge clk);
	endtask

	// Operand spread: full width, shortened magnitudes (short strings),
	// small negatives and the edge values.
	function automatic logic [63:0] random_operand();
		logic [63:0] full;
		full = {$urandom, $urandom};
		case ($urandom_range(5))
			0, 1: return full;
			2, 3: return full >> $urandom_range(63);
			4:    return -(full >> $urandom_range(48, 63));
			default: begin
				case ($urandom_range(3))
					0: return 64'd0;
					1: return '1;
					2: return {1'b1, 63'd0};
					default: return {1'b0, {63{1'b1}}};
				endcase
			end
		endcase
	endfunction

	// Receiver back-pressure, redrawn every cycle.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// ------------------------------------------------------------------
	// Result check: every accepted character against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		text_char_t exp_c;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_text.size() == 0) begin
				$display("%0t: unexpected character %h (last %b)", $time, character, last);
				error_count++;
			end else begin
				exp_c = pending_text.pop_front();
				if (character !== exp_c.ch) begin
					$display("%0t: character expected %h, got %h", $time, exp_c.ch, character);
					error_count++;
				end
				if (last !== exp_c.lst) begin
					$display("%0t: last expected %b, got %b", $time, exp_c.lst, last);
					error_count++;
				end
			end
		end
	end

	// Watchdog: cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= HANG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
				$display("testbench: errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Edge operands in every mode: zero, one, digit and letter boundaries,
	// the most negative value (longest string), -1, full-width patterns, nil.
	task automatic test_edge_values();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_request(MODE_DEC, 64'd0);
		send_request(MODE_DEC, 64'd1);
		send_request(MODE_DEC, 64'd9);
		send_request(MODE_DEC, 64'd10);
		send_request(MODE_DEC, '1);
		send_request(MODE_DEC, -64'd10);
		send_request(MODE_DEC, {1'b0, {63{1'b1}}});
		send_request(MODE_DEC, {1'b1, 63'd0});
		send_request(MODE_DEC, 64'd1000000000000000000);
		send_request(MODE_HEX_LO, 64'd0);
		send_request(MODE_HEX_LO, 64'h0123_4567_89ab_cdef);
		send_request(MODE_HEX_LO, '1);
		send_request(MODE_HEX_UP, 64'd0);
		send_request(MODE_HEX_UP, 64'hfedc_ba98_7654_3210);
		send_request(MODE_HEX_UP, 64'ha);
		send_request(MODE_PTR, 64'd0);
		send_request(MODE_PTR, 64'd1);
		send_request(MODE_PTR, 64'hdead_beef);
		send_request(MODE_PTR, '1);
	endtask

	task automatic test_random_operands(input int count, input int idle_pct,
			input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_request(2'($urandom_range(3)), random_operand());
	endtask

	// Short bursts, the sender holding off until the block has emptied out.
	task automatic test_drain_between_bursts();
		send_idle_pct  = 34;
		recv_stall_pct = 34;
		repeat (3) begin
			repeat (4)
				send_request(2'($urandom_range(3)), random_operand());
			in_valid <= 1'b0;
			while (pending_text.size() != 0)
				@(negedge clk);
			@(negedge clk);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_edge_values();
		test_random_operands(36, 0, 0);
		test_random_operands(36, 61, 0);
		test_random_operands(36, 0, 61);
		test_random_operands(36, 34, 34);
		test_drain_between_bursts();

		in_valid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);

		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
